@@ rtl/core/ffea_pkg.sv @@
// Package of the first-fit extent allocator.
// Holds the status codes and the command and status structs shared by the
// controller and the datapath. It depends on nothing else.
package ffea_pkg;

   localparam int DATA_W = 16;
   localparam int STATUS_W = 3;

   localparam logic [STATUS_W-1:0] STATUS_GRANTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_MEM   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RELEASED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NULL     = 3'd4;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Table read address relative to the index register.
   typedef enum logic [1:0] {
      RD_IDX,
      RD_NEXT,
      RD_PREV
   } rd_sel_type;

   // Source of the data written into the table.
   typedef enum logic [1:0] {
      WD_RDATA,
      WD_SPLIT,
      WD_NEW,
      WD_PREV
   } wr_sel_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_CLR,
      IDX_INC,
      IDX_DEC,
      IDX_COUNT
   } idx_op_type;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_SPLIT,
      RES_WHOLE,
      RES_BRK,
      RES_STATUS
   } res_sel_type;

   typedef struct packed {
      logic                capture;
      logic                rd_en;
      rd_sel_type          rd_sel;
      logic                wr_en;
      wr_sel_type          wr_sel;
      logic                wr_prev;
      idx_op_type          idx_op;
      logic                cnt_inc;
      logic                cnt_dec;
      logic                save_prev;
      logic                save_pos;
      logic                latch_merge;
      res_sel_type         res_sel;
      logic [STATUS_W-1:0] res_status;
      logic                brk_adv;
      logic                rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_release;
      logic addr_null;
      logic idx_ge_count;
      logic fit;
      logic split_ok;
      logic start_lt_bs;
      logic next_ok;
      logic idx_gt_pos;
      logic mnext;
      logic mprev;
      logic full;
      logic brk_ok;
   } stat_type;

endpackage

@@ rtl/core/ffea_datapath.sv @@
// Datapath of the first-fit extent allocator: extent table memory, index and
// count registers, break pointer, configuration registers and result registers.
// Depends on ffea_pkg; driven by ffea_controller.
module ffea_datapath #(
   parameter int MAX_EXTENTS  = 16,
   parameter int MIN_SPLIT    = 8,
   parameter int HEADER_BYTES = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ffea_pkg::cmd_type             cmd,
   output ffea_pkg::stat_type            stat,
   input  logic                          req_op,
   input  logic [ffea_pkg::DATA_W-1:0]   req_request_size,
   input  logic [ffea_pkg::DATA_W-1:0]   req_address,
   input  logic [ffea_pkg::DATA_W-1:0]   req_granted_size,
   output logic [ffea_pkg::STATUS_W-1:0] rsp_status,
   output logic [ffea_pkg::DATA_W-1:0]   rsp_grant_address,
   output logic [ffea_pkg::DATA_W-1:0]   rsp_grant_size,
   input  logic                          csr_wr,
   input  logic                          csr_sel_end,
   input  logic [ffea_pkg::DATA_W-1:0]   csr_wdata,
   output logic [ffea_pkg::DATA_W-1:0]   csr_rdata
);

   localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int IW = $clog2(MAX_EXTENTS + 1);
   localparam int DW = ffea_pkg::DATA_W;
   localparam logic [DW:0]   HDR17 = (DW+1)'(HEADER_BYTES);
   localparam logic [DW-1:0] HDR16 = DW'(HEADER_BYTES);
   localparam logic [DW:0]   MIN17 = (DW+1)'(MIN_SPLIT);
   localparam logic [DW:0]   MAX16 = {1'b0, {DW{1'b1}}};
   localparam logic [IW-1:0] MAXCNT = IW'(MAX_EXTENTS);

   logic [DW-1:0] mem_start [MAX_EXTENTS];
   logic [DW-1:0] mem_size  [MAX_EXTENTS];

   logic                op_ff;
   logic [DW:0]         need_ff, total_ff;
   logic [DW-1:0]       bs_ff, bz_ff, addr_ff;
   logic [DW-1:0]       cur_start_ff, cur_size_ff;
   logic [DW-1:0]       prev_start_ff, prev_size_ff;
   logic [DW-1:0]       bzm_ff;
   logic                mnext_ff;
   logic [IW-1:0]       idx_ff, idx_in, cnt_ff, pos_ff;
   logic [DW-1:0]       brk_ff, hs_ff, he_ff;
   logic [ffea_pkg::STATUS_W-1:0] res_status_ff;
   logic [DW-1:0]       res_addr_ff, res_size_ff;
   logic [ffea_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [DW-1:0]       rsp_addr_ff, rsp_size_ff;

   logic [DW:0]   req1, need_in, gsz17, bz17;
   logic [DW:0]   rem17, nxt_end, nxt_sum, prv_end, prv_sum;
   logic [DW+1:0] brk_sum;
   logic [IW-1:0] idx_p1;
   logic [AW-1:0] raddr, waddr;
   logic [DW-1:0] wdata_start, wdata_size;
   logic          mnext_in;

   // Padded size and header; the release extent with saturation.
   always_comb begin
      req1    = (req_request_size == '0) ? (DW+1)'(1) : {1'b0, req_request_size};
      need_in = (req1 + (DW+1)'(3)) & ~(DW+1)'(3);
      gsz17   = {1'b0, req_granted_size} + HDR17;
      bz17    = (gsz17 > MAX16) ? MAX16 : gsz17;
   end

   // Comparisons reported to the controller.
   always_comb begin
      idx_p1  = idx_ff + IW'(1);
      rem17   = {1'b0, cur_size_ff} - total_ff;
      nxt_end = {1'b0, bs_ff} + {1'b0, bz_ff};
      nxt_sum = {1'b0, bz_ff} + {1'b0, cur_size_ff};
      mnext_in = (idx_ff < cnt_ff) && (nxt_end == {1'b0, cur_start_ff}) &&
                 (nxt_sum <= MAX16);
      prv_end = {1'b0, prev_start_ff} + {1'b0, prev_size_ff};
      prv_sum = {1'b0, prev_size_ff} + {1'b0, bzm_ff};
      brk_sum = {2'b0, brk_ff} + {1'b0, total_ff};
      stat.is_release   = op_ff;
      stat.addr_null    = (addr_ff == '0);
      stat.idx_ge_count = (idx_ff >= cnt_ff);
      stat.fit          = ({1'b0, cur_size_ff} >= total_ff);
      stat.split_ok     = (rem17 >= MIN17);
      stat.start_lt_bs  = (cur_start_ff < bs_ff);
      stat.next_ok      = (idx_p1 < cnt_ff);
      stat.idx_gt_pos   = (idx_ff > pos_ff);
      stat.mnext        = mnext_ff;
      stat.mprev        = (idx_ff != '0) && (prv_end == {1'b0, bs_ff}) &&
                          (prv_sum <= MAX16);
      stat.full         = (cnt_ff >= MAXCNT);
      stat.brk_ok       = (brk_sum <= {2'b0, he_ff});
   end

   // Table addresses and write data.
   always_comb begin
      case (cmd.rd_sel)
         ffea_pkg::RD_NEXT: raddr = idx_p1[AW-1:0];
         ffea_pkg::RD_PREV: raddr = idx_ff[AW-1:0] - AW'(1);
         default:           raddr = idx_ff[AW-1:0];
      endcase
      waddr = cmd.wr_prev ? (idx_ff[AW-1:0] - AW'(1)) : idx_ff[AW-1:0];
      case (cmd.wr_sel)
         ffea_pkg::WD_SPLIT: begin
            wdata_start = cur_start_ff + total_ff[DW-1:0];
            wdata_size  = rem17[DW-1:0];
         end
         ffea_pkg::WD_NEW: begin
            wdata_start = bs_ff;
            wdata_size  = bzm_ff;
         end
         ffea_pkg::WD_PREV: begin
            wdata_start = prev_start_ff;
            wdata_size  = prv_sum[DW-1:0];
         end
         default: begin
            wdata_start = cur_start_ff;
            wdata_size  = cur_size_ff;
         end
      endcase
   end

   // The extent table is a memory with one read and one write port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_start[waddr] <= wdata_start;
         mem_size[waddr]  <= wdata_size;
      end
      if (cmd.rd_en) begin
         cur_start_ff <= mem_start[raddr];
         cur_size_ff  <= mem_size[raddr];
      end
   end

   // Index register update.
   always_comb begin
      case (cmd.idx_op)
         ffea_pkg::IDX_CLR:   idx_in = '0;
         ffea_pkg::IDX_INC:   idx_in = idx_p1;
         ffea_pkg::IDX_DEC:   idx_in = idx_ff - IW'(1);
         ffea_pkg::IDX_COUNT: idx_in = cnt_ff;
         default:             idx_in = idx_ff;
      endcase
   end

   // Control registers: count, break pointer and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         brk_ff <= '0;
         hs_ff  <= '0;
         he_ff  <= '1;
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.cnt_inc) cnt_ff <= cnt_ff + IW'(1);
         else if (cmd.cnt_dec) cnt_ff <= cnt_ff - IW'(1);
         if (csr_wr && !csr_sel_end) begin
            hs_ff  <= csr_wdata;
            brk_ff <= csr_wdata;
         end else if (cmd.brk_adv) begin
            brk_ff <= brk_sum[DW-1:0];
         end
         if (csr_wr && csr_sel_end) he_ff <= csr_wdata;
      end
   end

   assign csr_rdata = csr_sel_end ? he_ff : hs_ff;

   // Request capture, scan side registers and result staging.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         need_ff  <= need_in;
         total_ff <= need_in + HDR17;
         addr_ff  <= req_address;
         bs_ff    <= req_address - HDR16;
         bz_ff    <= bz17[DW-1:0];
         res_status_ff <= ffea_pkg::STATUS_GRANTED;
         res_addr_ff   <= '0;
         res_size_ff   <= '0;
      end
      if (cmd.save_prev) begin
         prev_start_ff <= cur_start_ff;
         prev_size_ff  <= cur_size_ff;
      end
      if (cmd.save_pos) pos_ff <= idx_ff;
      if (cmd.latch_merge) begin
         mnext_ff <= mnext_in;
         bzm_ff   <= mnext_in ? nxt_sum[DW-1:0] : bz_ff;
      end
      case (cmd.res_sel)
         ffea_pkg::RES_SPLIT: begin
            res_status_ff <= ffea_pkg::STATUS_GRANTED;
            res_addr_ff   <= cur_start_ff + HDR16;
            res_size_ff   <= need_ff[DW-1:0];
         end
         ffea_pkg::RES_WHOLE: begin
            res_status_ff <= ffea_pkg::STATUS_GRANTED;
            res_addr_ff   <= cur_start_ff + HDR16;
            res_size_ff   <= cur_size_ff - HDR16;
         end
         ffea_pkg::RES_BRK: begin
            res_status_ff <= ffea_pkg::STATUS_GRANTED;
            res_addr_ff   <= brk_ff + HDR16;
            res_size_ff   <= need_ff[DW-1:0];
         end
         ffea_pkg::RES_STATUS: begin
            res_status_ff <= cmd.res_status;
            res_addr_ff   <= '0;
            res_size_ff   <= '0;
         end
         default: ;
      endcase
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_size_ff   <= res_size_ff;
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_grant_address = rsp_addr_ff;
   assign rsp_grant_size    = rsp_size_ff;

endmodule

@@ rtl/core/ffea_controller.sv @@
// Controller of the first-fit extent allocator: sequences table scans,
// shifts and the result handshake. Depends on ffea_pkg; drives ffea_datapath.
module ffea_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ffea_pkg::stat_type  stat,
   output ffea_pkg::cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, A_RD, A_CHK, A_BRK, D_RD, D_WR,
      R_RD, R_CMP, R_MRG, R_DEC, U_RD, U_WR, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      cmd = '0;
      cmd.rd_sel = ffea_pkg::RD_IDX;
      cmd.wr_sel = ffea_pkg::WD_RDATA;
      cmd.idx_op = ffea_pkg::IDX_HOLD;
      cmd.res_sel = ffea_pkg::RES_NONE;
      cmd.res_status = ffea_pkg::STATUS_GRANTED;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               cmd.idx_op  = ffea_pkg::IDX_CLR;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            if (!stat.is_release) begin
               state_in = A_RD;
            end else if (stat.addr_null) begin
               cmd.res_sel    = ffea_pkg::RES_STATUS;
               cmd.res_status = ffea_pkg::STATUS_NULL;
               state_in       = S_DONE;
            end else begin
               state_in = R_RD;
            end
         end
         A_RD: begin
            if (stat.idx_ge_count) begin
               state_in = A_BRK;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = A_CHK;
            end
         end
         A_CHK: begin
            if (stat.fit && stat.split_ok) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = ffea_pkg::WD_SPLIT;
               cmd.res_sel = ffea_pkg::RES_SPLIT;
               state_in    = S_DONE;
            end else if (stat.fit) begin
               cmd.res_sel = ffea_pkg::RES_WHOLE;
               state_in    = D_RD;
            end else begin
               cmd.idx_op = ffea_pkg::IDX_INC;
               state_in   = A_RD;
            end
         end
         A_BRK: begin
            if (stat.brk_ok) begin
               cmd.res_sel = ffea_pkg::RES_BRK;
               cmd.brk_adv = 1'b1;
            end else begin
               cmd.res_sel    = ffea_pkg::RES_STATUS;
               cmd.res_status = ffea_pkg::STATUS_NO_MEM;
            end
            state_in = S_DONE;
         end
         // Close the gap left by a removed entry, one entry at a time.
         D_RD: begin
            if (stat.next_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ffea_pkg::RD_NEXT;
               state_in   = D_WR;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end
         end
         D_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.idx_op = ffea_pkg::IDX_INC;
            state_in   = D_RD;
         end
         // Find the insert position in address order.
         R_RD: begin
            if (stat.idx_ge_count) begin
               state_in = R_MRG;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = R_CMP;
            end
         end
         R_CMP: begin
            if (stat.start_lt_bs) begin
               cmd.save_prev = 1'b1;
               cmd.idx_op    = ffea_pkg::IDX_INC;
               state_in      = R_RD;
            end else begin
               state_in = R_MRG;
            end
         end
         R_MRG: begin
            cmd.latch_merge = 1'b1;
            state_in        = R_DEC;
         end
         R_DEC: begin
            cmd.res_sel    = ffea_pkg::RES_STATUS;
            cmd.res_status = ffea_pkg::STATUS_RELEASED;
            if (stat.mnext && stat.mprev) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = ffea_pkg::WD_PREV;
               cmd.wr_prev = 1'b1;
               state_in    = D_RD;
            end else if (stat.mnext) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = ffea_pkg::WD_NEW;
               state_in   = S_DONE;
            end else if (stat.mprev) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = ffea_pkg::WD_PREV;
               cmd.wr_prev = 1'b1;
               state_in    = S_DONE;
            end else if (stat.full) begin
               cmd.res_status = ffea_pkg::STATUS_DROPPED;
               state_in       = S_DONE;
            end else begin
               cmd.save_pos = 1'b1;
               cmd.idx_op   = ffea_pkg::IDX_COUNT;
               state_in     = U_RD;
            end
         end
         // Open a slot at the insert position, top entry first.
         U_RD: begin
            if (stat.idx_gt_pos) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ffea_pkg::RD_PREV;
               state_in   = U_WR;
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = ffea_pkg::WD_NEW;
               cmd.cnt_inc = 1'b1;
               state_in    = S_DONE;
            end
         end
         U_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.idx_op = ffea_pkg::IDX_DEC;
            state_in   = U_RD;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

endmodule

@@ rtl/core/first_fit_extent_allocator_top.sv @@
// Top level of the first-fit extent allocator; joins ffea_controller and
// ffea_datapath. Depends on ffea_pkg.
//
// One request is handled at a time. An allocate scans table entries up to the
// first fit, then moves entries down when a whole extent is taken; a release
// scans entries up to its position, then moves entries up or down. The entries
// scanned and the entries moved never add up to more than the table holds. The
// time a request takes is set by the single read and write port of the extent
// table memory.
// The result is held in an output register, so the next request is taken
// while it waits. heap_start (address 0) also reloads the break pointer;
// heap_end is at address 4.
module first_fit_extent_allocator_top #(
   parameter int MAX_EXTENTS  = 16,
   parameter int MIN_SPLIT    = 8,
   parameter int HEADER_BYTES = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [ffea_pkg::DATA_W-1:0]   req_request_size,
   input  logic [ffea_pkg::DATA_W-1:0]   req_address,
   input  logic [ffea_pkg::DATA_W-1:0]   req_granted_size,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ffea_pkg::STATUS_W-1:0] rsp_status,
   output logic [ffea_pkg::DATA_W-1:0]   rsp_grant_address,
   output logic [ffea_pkg::DATA_W-1:0]   rsp_grant_size,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   ffea_pkg::cmd_type  cmd;
   ffea_pkg::stat_type stat;
   logic                        csr_wr;
   logic [ffea_pkg::DATA_W-1:0] csr_rdata;

   // Register write strobe; paddr bit 2 selects the register.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = {16'b0, csr_rdata};

   ffea_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffea_datapath #(
      .MAX_EXTENTS  (MAX_EXTENTS),
      .MIN_SPLIT    (MIN_SPLIT),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_op),
      .req_request_size  (req_request_size),
      .req_address       (req_address),
      .req_granted_size  (req_granted_size),
      .rsp_status        (rsp_status),
      .rsp_grant_address (rsp_grant_address),
      .rsp_grant_size    (rsp_grant_size),
      .csr_wr            (csr_wr),
      .csr_sel_end       (paddr[2]),
      .csr_wdata         (pwdata[15:0]),
      .csr_rdata         (csr_rdata)
   );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench of the first-fit extent allocator.
// Drives allocate and release items and checks every result against a local
// model of the free-extent table. Depends on ffea_pkg and the top level.
`timescale 1ns / 100ps

module testbench;

   localparam int MAX_EXT = 16;
   localparam int MIN_SPL = 8;
   localparam int HDR = 4;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic [2:0] ADDR_HEAP_START = 3'd0;
   localparam logic [2:0] ADDR_HEAP_END = 3'd4;

   typedef struct packed {
      logic [ffea_pkg::STATUS_W-1:0] status;
      logic [ffea_pkg::DATA_W-1:0]   address;
      logic [ffea_pkg::DATA_W-1:0]   size;
   } grant_type;

   typedef struct {
      logic      op;
      int        req_size;
      int        addr;
      int        gsize;
      logic      known;
      grant_type result;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = 1'b0;
   logic [ffea_pkg::DATA_W-1:0] req_request_size = '0;
   logic [ffea_pkg::DATA_W-1:0] req_address = '0;
   logic [ffea_pkg::DATA_W-1:0] req_granted_size = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ffea_pkg::STATUS_W-1:0] rsp_status;
   logic [ffea_pkg::DATA_W-1:0] rsp_grant_address;
   logic [ffea_pkg::DATA_W-1:0] rsp_grant_size;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   first_fit_extent_allocator_top dut (.*);

   always #5 clock = ~clock;

   // Model state of the free table and the break.
   int unsigned free_start[MAX_EXT];
   int unsigned free_size[MAX_EXT];
   int unsigned free_count;
   int unsigned brk;
   int unsigned heap_lo;
   int unsigned heap_hi;

   grant_type pending_grants[$];
   int unsigned live_addr[$];
   int unsigned live_size[$];
   int errors = 0;
   int results_seen = 0;
   bit calm = 1'b0;
   longint cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void remove_extent(int unsigned i);
      for (int unsigned k = i; k + 1 < free_count; k++) begin
         free_start[k] = free_start[k + 1];
         free_size[k] = free_size[k + 1];
      end
      if (free_count > 0) free_count--;
   endfunction

   // Computes the result of one item and updates the model table.
   function automatic grant_type predict_grant(logic op, int unsigned rsz,
                                               int unsigned ad, int unsigned gs);
      grant_type g;
      int unsigned need, total, rem, bs, bz, pos;
      bit mnext, mprev;
      g = '0;
      if (op == ffea_pkg::OP_ALLOC) begin
         if (rsz == 0) rsz = 1;
         need = (rsz + 3) & ~32'd3;
         total = need + HDR;
         for (int unsigned i = 0; i < free_count; i++) begin
            if (free_size[i] >= total) begin
               g.status = ffea_pkg::STATUS_GRANTED;
               g.address = 16'(free_start[i] + HDR);
               rem = free_size[i] - total;
               if (rem >= MIN_SPL) begin
                  free_start[i] = (free_start[i] + total) & 16'hFFFF;
                  free_size[i] = rem;
                  g.size = 16'(need);
               end else begin
                  g.size = 16'(free_size[i] - HDR);
                  remove_extent(i);
               end
               return g;
            end
         end
         if (brk + total <= heap_hi) begin
            g.status = ffea_pkg::STATUS_GRANTED;
            g.address = 16'(brk + HDR);
            g.size = 16'(need);
            brk = (brk + total) & 16'hFFFF;
         end else begin
            g.status = ffea_pkg::STATUS_NO_MEM;
         end
         return g;
      end
      if (ad == 0) begin
         g.status = ffea_pkg::STATUS_NULL;
         return g;
      end
      bs = (ad - HDR) & 16'hFFFF;
      bz = gs + HDR;
      if (bz > 16'hFFFF) bz = 16'hFFFF;
      pos = 0;
      while (pos < free_count && free_start[pos] < bs) pos++;
      mnext = 0;
      mprev = 0;
      if (pos < free_count && bs + bz == free_start[pos] &&
          bz + free_size[pos] <= 16'hFFFF) begin
         mnext = 1;
         bz += free_size[pos];
      end
      if (pos > 0 && free_start[pos - 1] + free_size[pos - 1] == bs &&
          free_size[pos - 1] + bz <= 16'hFFFF)
         mprev = 1;
      if (mnext && mprev) begin
         free_size[pos - 1] += bz;
         remove_extent(pos);
      end else if (mnext) begin
         free_start[pos] = bs;
         free_size[pos] = bz;
      end else if (mprev) begin
         free_size[pos - 1] += bz;
      end else begin
         if (free_count >= MAX_EXT) begin
            g.status = ffea_pkg::STATUS_DROPPED;
            return g;
         end
         for (int unsigned k = free_count; k > pos; k--) begin
            free_start[k] = free_start[k - 1];
            free_size[k] = free_size[k - 1];
         end
         free_start[pos] = bs;
         free_size[pos] = bz;
         free_count++;
      end
      g.status = ffea_pkg::STATUS_RELEASED;
      return g;
   endfunction

   // Result side: random stalls and comparison with the oldest expectation.
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected result status %0d", $time, rsp_status);
            errors++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_status !== want.status || rsp_grant_address !== want.address ||
                rsp_grant_size !== want.size) begin
               $display("%0t: expected %0d/%h/%h, got %0d/%h/%h", $time,
                        want.status, want.address, want.size,
                        rsp_status, rsp_grant_address, rsp_grant_size);
               errors++;
            end
         end
      end
   end

   initial begin : stall_gen
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   task automatic csr_write(logic [2:0] a, int unsigned v);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= a;
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (a == ADDR_HEAP_START) begin
         heap_lo = v & 16'hFFFF;
         brk = heap_lo;
      end else begin
         heap_hi = v & 16'hFFFF;
      end
   endtask

   // Sends one item, with an optional random gap before it.
   task automatic send_item(logic op, int unsigned rsz, int unsigned ad,
                            int unsigned gs, bit known, grant_type fixed);
      grant_type g;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_request_size <= 16'(rsz);
      req_address <= 16'(ad);
      req_granted_size <= 16'(gs);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      g = predict_grant(op, rsz & 16'hFFFF, ad & 16'hFFFF, gs & 16'hFFFF);
      if (known && g != fixed) begin
         $display("%0t: directed row expected %0d/%h/%h, model %0d/%h/%h", $time,
                  fixed.status, fixed.address, fixed.size, g.status, g.address, g.size);
         errors++;
      end
      pending_grants.push_back(g);
      if (op == ffea_pkg::OP_ALLOC && g.status == ffea_pkg::STATUS_GRANTED) begin
         live_addr.push_back(32'(g.address));
         live_size.push_back(32'(g.size));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (4 * MAX_EXT + 20) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      int unsigned i, a, s;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_item(ffea_pkg::OP_ALLOC, $urandom_range(0, 3) == 0 ?
                                  $urandom_range(0, 65535) : $urandom_range(0, 80),
                                  $urandom, $urandom, 1'b0, '0);
            4, 5, 6, 7: begin
               if (live_addr.size() != 0) begin
                  i = $urandom_range(0, live_addr.size() - 1);
                  a = live_addr[i];
                  s = live_size[i];
                  live_addr.delete(i);
                  live_size.delete(i);
               end else begin
                  a = $urandom_range(1, 65535);
                  s = $urandom_range(0, 60);
               end
               send_item(ffea_pkg::OP_RELEASE, $urandom, a, s, 1'b0, '0);
            end
            8: send_item(ffea_pkg::OP_RELEASE, $urandom,
                         $urandom_range(0, 3) == 0 ? 0 : $urandom,
                         $urandom, 1'b0, '0);
            default: send_item(1'($urandom_range(0, 1)), $urandom, $urandom,
                               $urandom, 1'b0, '0);
         endcase
      end
   endtask

   row_type rows[$];

   function automatic row_type mk(logic op, int rsz, int ad, int gs, logic known,
                                  logic [2:0] st, int ga, int gz);
      row_type r;
      r.op = op;
      r.req_size = rsz;
      r.addr = ad;
      r.gsize = gs;
      r.known = known;
      r.result = '{st, ga[15:0], gz[15:0]};
      return r;
   endfunction

   initial begin
      free_count = 0;
      heap_lo = 0;
      heap_hi = 16'hFFFF;
      brk = 0;
      for (int i = 0; i < MAX_EXT; i++) begin
         free_start[i] = 0;
         free_size[i] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: zero size, extremes, null, low address, huge release.
      rows.push_back(mk(ffea_pkg::OP_ALLOC, 0, 0, 0, 1, ffea_pkg::STATUS_GRANTED, 4, 4));
      rows.push_back(mk(ffea_pkg::OP_ALLOC, 5, 0, 0, 1, ffea_pkg::STATUS_GRANTED, 12, 8));
      rows.push_back(mk(ffea_pkg::OP_ALLOC, 65535, 0, 0, 1, ffea_pkg::STATUS_NO_MEM, 0, 0));
      rows.push_back(mk(ffea_pkg::OP_ALLOC, 65532, 0, 0, 1, ffea_pkg::STATUS_NO_MEM, 0, 0));
      rows.push_back(mk(ffea_pkg::OP_RELEASE, 0, 0, 123, 1, ffea_pkg::STATUS_NULL, 0, 0));
      rows.push_back(mk(ffea_pkg::OP_RELEASE, 0, 4, 4, 1, ffea_pkg::STATUS_RELEASED, 0, 0));
      rows.push_back(mk(ffea_pkg::OP_RELEASE, 0, 12, 8, 1, ffea_pkg::STATUS_RELEASED, 0, 0));
      rows.push_back(mk(ffea_pkg::OP_ALLOC, 16, 0, 0, 1, ffea_pkg::STATUS_GRANTED, 4, 16));
      rows.push_back(mk(ffea_pkg::OP_RELEASE, 0, 2, 100, 0, 0, 0, 0));
      rows.push_back(mk(ffea_pkg::OP_RELEASE, 0, 65535, 65535, 0, 0, 0, 0));
      rows.push_back(mk(ffea_pkg::OP_RELEASE, 0, 40000, 65535, 0, 0, 0, 0));
      rows.push_back(mk(ffea_pkg::OP_ALLOC, 65535, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < 18; i++)
         rows.push_back(mk(ffea_pkg::OP_RELEASE, 0, 1000 + 64 * i, 8, 0, 0, 0, 0));
      foreach (rows[i])
         send_item(rows[i].op, rows[i].req_size, rows[i].addr, rows[i].gsize,
                   rows[i].known, rows[i].result);
      drain();

      // Several heap settings, extremes included.
      csr_write(ADDR_HEAP_START, 16'h0100);
      csr_write(ADDR_HEAP_END, 16'h0400);
      random_phase(400);
      drain();
      csr_write(ADDR_HEAP_START, 16'hFFFF);
      csr_write(ADDR_HEAP_END, 16'h0000);
      random_phase(200);
      drain();
      csr_write(ADDR_HEAP_START, 16'h0000);
      csr_write(ADDR_HEAP_END, 16'hFFFF);
      random_phase(600);
      drain();
      csr_write(ADDR_HEAP_START, 16'h8000);
      csr_write(ADDR_HEAP_END, 16'h9000);
      random_phase(230);
      calm = 1'b1;
      random_phase(200);
      drain();

      $display("Ran %0d results through directed rows and four heap settings,",
               results_seen);
      $display("covering splits, merges, table overflow, null and out-of-memory.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
